// ===== src/cebp_pkg.sv =====
// Package for the configuration entry byte parser.
// Holds the request and result payload types, byte class record, kind codes and character codes.
// No dependencies.
`default_nettype none

package cebp_pkg;

	// Request payload: one text byte or the end-of-stream mark.
	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_end;
	} request_t;

	// Result payload: what happened and the byte that goes with it.
	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] out_byte;
	} result_t;

	// Byte classes worked out by the front end and carried to the back end.
	typedef struct packed {
		logic       is_end;
		logic       is_hash;
		logic       is_blank;
		logic       is_newline;
		logic       is_nul;
		logic       is_ident;
		logic       is_eq;
		logic       is_quote;
		logic [7:0] data;
	} byte_class_t;

	// Result kinds.
	localparam logic [2:0] KIND_NAME   = 3'd0;
	localparam logic [2:0] KIND_VALUE  = 3'd1;
	localparam logic [2:0] KIND_DONE   = 3'd2;
	localparam logic [2:0] KIND_UNTERM = 3'd3;
	localparam logic [2:0] KIND_TRUNC  = 3'd4;
	localparam logic [2:0] KIND_END    = 3'd5;

	// Characters the parser looks for.
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_EQ      = 8'h3D;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_DASH    = 8'h2D;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_NUL     = 8'h00;

endpackage

`default_nettype wire

// ===== src/cebp_fifo.sv =====
// Small synchronous queue used between the parser stages and at the output.
// Generic over the entry type; no package dependency.
`default_nettype none

module cebp_fifo #(
	parameter type T       = logic,
	parameter int  ADDR_W  = 1
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  T          wr_data,
	output logic      full,
	input  wire logic pop,
	output T          rd_data,
	output logic      empty
);

	localparam int DEPTH = 2 ** ADDR_W;

	T                  entry_q [DEPTH];
	logic [ADDR_W-1:0] wr_ptr_q;
	logic [ADDR_W-1:0] rd_ptr_q;
	logic [ADDR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	// Status flags come straight from the registered fill count.
	assign full    = (count_q == (ADDR_W + 1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/cebp_front.sv =====
// Front end of the parser: takes each request and sorts its byte into classes.
// Depends on cebp_pkg.
`default_nettype none

module cebp_front
	import cebp_pkg::*;
(
	input  request_t    request,
	output byte_class_t cls
);

	logic [7:0] b;
	logic       is_lower;
	logic       is_upper;
	logic       is_digit;

	assign b = request.in_byte;

	// Character ranges for identifier bytes.
	assign is_lower = (b >= 8'h61) && (b <= 8'h7A);
	assign is_upper = (b >= 8'h41) && (b <= 8'h5A);
	assign is_digit = (b >= 8'h30) && (b <= 8'h39);

	// Class record handed to the back end through the queue.
	always_comb begin
		cls.is_end     = request.is_end;
		cls.is_hash    = (b == CH_HASH);
		cls.is_blank   = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NEWLINE);
		cls.is_newline = (b == CH_NEWLINE);
		cls.is_nul     = (b == CH_NUL);
		cls.is_ident   = is_lower || is_upper || is_digit ||
		                 (b == CH_UNDER) || (b == CH_DASH) || (b == CH_DOT);
		cls.is_eq      = (b == CH_EQ);
		cls.is_quote   = (b == CH_QUOTE);
		cls.data       = b;
	end

endmodule

`default_nettype wire

// ===== src/cebp_back.sv =====
// Back end of the parser: the phase machine that turns classified bytes into results.
// Depends on cebp_pkg.
`default_nettype none

module cebp_back
	import cebp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  byte_class_t cls,
	input  wire logic  cls_valid,
	output logic       cls_take,
	input  wire logic  res_full,
	output logic       res_push,
	output result_t    res
);

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_COMMENT = 3'd1;
	localparam logic [2:0] PH_NAME    = 3'd2;
	localparam logic [2:0] PH_SEEK_EQ = 3'd3;
	localparam logic [2:0] PH_SEEK_QT = 3'd4;
	localparam logic [2:0] PH_VALUE   = 3'd5;
	localparam logic [2:0] PH_HALT    = 3'd6;

	logic [2:0] phase_q;
	logic [2:0] phase_next;
	logic       emit;

	// One classified byte is handled whenever there is room for its result.
	assign cls_take = cls_valid && !res_full;
	assign res_push = cls_take && emit;

	// Next phase and result for the byte at the head of the queue.
	always_comb begin
		phase_next   = phase_q;
		emit         = 1'b0;
		res.kind     = KIND_END;
		res.out_byte = '0;
		unique case (phase_q)
			PH_IDLE, PH_COMMENT: begin
				if (cls.is_end) begin
					phase_next = PH_IDLE;
					emit       = 1'b1;
					res.kind   = KIND_END;
				end else if (phase_q == PH_COMMENT) begin
					if (cls.is_newline) begin
						phase_next = PH_IDLE;
					end
				end else if (cls.is_hash) begin
					phase_next = PH_COMMENT;
				end else if (!cls.is_blank) begin
					// Any other byte starts a name and is emitted as its first byte.
					phase_next   = PH_NAME;
					emit         = 1'b1;
					res.kind     = KIND_NAME;
					res.out_byte = cls.data;
				end
			end
			PH_NAME: begin
				if (cls.is_end) begin
					phase_next = PH_IDLE;
					emit       = 1'b1;
					res.kind   = KIND_TRUNC;
				end else if (cls.is_ident) begin
					emit         = 1'b1;
					res.kind     = KIND_NAME;
					res.out_byte = cls.data;
				end else begin
					// The byte that ends a name may itself be the equals sign.
					phase_next = cls.is_eq ? PH_SEEK_QT : PH_SEEK_EQ;
				end
			end
			PH_SEEK_EQ: begin
				if (cls.is_end) begin
					phase_next = PH_IDLE;
					emit       = 1'b1;
					res.kind   = KIND_TRUNC;
				end else if (cls.is_eq) begin
					phase_next = PH_SEEK_QT;
				end
			end
			PH_SEEK_QT: begin
				if (cls.is_end) begin
					phase_next = PH_IDLE;
					emit       = 1'b1;
					res.kind   = KIND_TRUNC;
				end else if (cls.is_quote) begin
					phase_next = PH_VALUE;
				end
			end
			PH_VALUE: begin
				if (cls.is_end) begin
					phase_next = PH_IDLE;
					emit       = 1'b1;
					res.kind   = KIND_TRUNC;
				end else if (cls.is_quote) begin
					phase_next = PH_IDLE;
					emit       = 1'b1;
					res.kind   = KIND_DONE;
				end else if (cls.is_nul || cls.is_newline) begin
					phase_next = PH_HALT;
					emit       = 1'b1;
					res.kind   = KIND_UNTERM;
				end else begin
					emit         = 1'b1;
					res.kind     = KIND_VALUE;
					res.out_byte = cls.data;
				end
			end
			default: begin
				// Halted: bytes are drained and dropped until reset.
				phase_next = phase_q;
			end
		endcase
	end

	// Phase register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (cls_take) begin
			phase_q <= phase_next;
		end
	end

	// Once halted, the parser stays halted.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALT |=> phase_q == PH_HALT)
		else $error("parser left the halted phase");

	// Nothing is produced while halted.
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALT |-> !res_push)
		else $error("result produced while halted");

	// Only name and value results carry a byte.
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res.kind != KIND_NAME && res.kind != KIND_VALUE |-> res.out_byte == '0)
		else $error("status result carries a nonzero byte");

	// An unterminated value always sends the parser into the halted phase.
	a_unterm_halts: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res.kind == KIND_UNTERM |=> phase_q == PH_HALT)
		else $error("unterminated value did not halt the parser");

endmodule

`default_nettype wire

// ===== src/config_entry_byte_parser.sv =====
// Top level of the configuration entry byte parser.
// Depends on cebp_pkg, cebp_fifo, cebp_front and cebp_back.
//
// Usage:
//   Requests enter as a queue: drive request and raise push; the request is
//   taken at a clock edge where push is high and full is low. Each request is
//   one text byte, or an end-of-stream mark when is_end is set.
//   Results leave as a queue: while empty is low, result holds the oldest
//   result (kind and byte); raise pop to take it.
//   A byte that is skipped (blank space, comments, text between the name and
//   the opening quote) yields no result.
// Flow:
//   A request is registered in the middle queue, and its result, if any, in the output queue.
//   One request is taken every cycle while full is low; the phase machine in the back end
//   handles one classified byte per cycle while the output queue is not full.
// Reset:
//   arst_n clears both queues and returns the parser to idle between entries.
//   After an unterminated value the parser drops all requests until reset.
// Stalls:
//   When pop stays low, the output queue fills, the back end stops, the middle
//   queue fills and full rises. No request or result is lost.
`default_nettype none

module config_entry_byte_parser
	import cebp_pkg::*;
#(
	parameter int MID_ADDR_W = 1,
	parameter int OUT_ADDR_W = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  request_t  request,
	output logic      full,
	input  wire logic pop,
	output result_t   result,
	output logic      empty
);

	byte_class_t cls_in;
	byte_class_t cls_head;
	logic        mid_empty;
	logic        cls_take;
	logic        res_full;
	logic        res_push;
	result_t     res;

	// Classify each incoming byte.
	cebp_front u_front (
		.request (request),
		.cls     (cls_in)
	);

	// Queue between classification and the phase machine.
	cebp_fifo #(
		.T      (byte_class_t),
		.ADDR_W (MID_ADDR_W)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (cls_in),
		.full    (full),
		.pop     (cls_take),
		.rd_data (cls_head),
		.empty   (mid_empty)
	);

	// Phase machine.
	cebp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls       (cls_head),
		.cls_valid (!mid_empty),
		.cls_take  (cls_take),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	// Result queue toward the receiver.
	cebp_fifo #(
		.T      (result_t),
		.ADDR_W (OUT_ADDR_W)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res),
		.full    (res_full),
		.pop     (pop),
		.rd_data (result),
		.empty   (empty)
	);

endmodule

`default_nettype wire
